@@ sv/iutc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the timestamp-to-epoch block.
// No dependencies; imported by every module of the block.
package iutc_pkg;

  // Layout of YYYY-MM-DDTHH:MM:SSZ
  localparam logic [4:0] TS_LAST_POS = 5'd19;
  localparam logic [4:0] TS_LENGTH   = 5'd20;
  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [4:0] POS_DASH_A  = 5'd4;
  localparam logic [4:0] POS_DASH_B  = 5'd7;
  localparam logic [4:0] POS_T       = 5'd10;
  localparam logic [4:0] POS_COLON_A = 5'd13;
  localparam logic [4:0] POS_COLON_B = 5'd16;
  localparam logic [4:0] POS_YEAR_END   = 5'd3;
  localparam logic [4:0] POS_MONTH_END  = 5'd6;
  localparam logic [4:0] POS_DAY_END    = 5'd9;
  localparam logic [4:0] POS_HOUR_END   = 5'd12;
  localparam logic [4:0] POS_MINUTE_END = 5'd15;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [13:0] LEAPS_1969  = 14'd477;
  localparam logic [12:0] DIV100_MUL  = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [6:0]  MAX_MONTH   = 7'd12;
  localparam logic [6:0]  MAX_DAY     = 7'd31;
  localparam logic [6:0]  MAX_HOUR    = 7'd23;
  localparam logic [6:0]  MAX_MINUTE  = 7'd59;
  localparam logic [6:0]  MAX_SECOND  = 7'd60;
  localparam logic [6:0]  FEBRUARY    = 7'd2;

  // One parsed string, handed from the parser to the converter.
  typedef struct packed {
    logic        fmt_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } ts_rec_t;

  function automatic logic [13:0] acc_step14(input logic [13:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {10'd0, d};
  endfunction

  function automatic logic [6:0] acc_step7(input logic [6:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {3'd0, d};
  endfunction

  // Days in the year before the first of each month (index 0 is January).
  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/iutc_parse.sv @@
`timescale 1ns / 1ps
// Front end: checks the character stream and collects the decimal fields.
// Depends on iutc_pkg; pushes one ts_rec_t per string into the queue.
module iutc_parse import iutc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       push,
  output ts_rec_t    push_data
);

  logic [4:0]  char_position, char_position_next;
  logic [13:0] year_accum, year_accum_next;
  logic [6:0]  month_accum, month_accum_next;
  logic [6:0]  day_accum, day_accum_next;
  logic [6:0]  hour_accum, hour_accum_next;
  logic [6:0]  minute_accum, minute_accum_next;
  logic [6:0]  second_accum, second_accum_next;
  logic        format_error, format_error_next;
  logic        digit;
  logic [3:0]  d;
  logic        err_now;

  assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign d     = digit ? 4'(char_code - CH_ZERO) : 4'd0;

  always_comb begin
    err_now            = format_error;
    year_accum_next    = year_accum;
    month_accum_next   = month_accum;
    day_accum_next     = day_accum;
    hour_accum_next    = hour_accum;
    minute_accum_next  = minute_accum;
    second_accum_next  = second_accum;
    priority if (char_position >= TS_LENGTH) begin
      err_now = 1'b1;
    end else if (char_position == POS_DASH_A || char_position == POS_DASH_B) begin
      if (char_code != CH_DASH) err_now = 1'b1;
    end else if (char_position == POS_T) begin
      if (char_code != CH_T) err_now = 1'b1;
    end else if (char_position == POS_COLON_A || char_position == POS_COLON_B) begin
      if (char_code != CH_COLON) err_now = 1'b1;
    end else if (char_position == TS_LAST_POS) begin
      if (char_code != CH_Z) err_now = 1'b1;
    end else if (!digit) begin
      err_now = 1'b1;
    end else if (char_position <= POS_YEAR_END) begin
      year_accum_next = acc_step14(year_accum, d);
    end else if (char_position <= POS_MONTH_END) begin
      month_accum_next = acc_step7(month_accum, d);
    end else if (char_position <= POS_DAY_END) begin
      day_accum_next = acc_step7(day_accum, d);
    end else if (char_position <= POS_HOUR_END) begin
      hour_accum_next = acc_step7(hour_accum, d);
    end else if (char_position <= POS_MINUTE_END) begin
      minute_accum_next = acc_step7(minute_accum, d);
    end else begin
      second_accum_next = acc_step7(second_accum, d);
    end
    format_error_next  = err_now;
    char_position_next = (char_position < POS_MAX) ? char_position + 5'd1 : char_position;
    if (last_char) begin
      // A new string starts after every final character.
      char_position_next = '0;
      year_accum_next    = '0;
      month_accum_next   = '0;
      day_accum_next     = '0;
      hour_accum_next    = '0;
      minute_accum_next  = '0;
      second_accum_next  = '0;
      format_error_next  = 1'b0;
    end
  end

  // The final character of a good string is the 'Z', so the fields are complete.
  assign push             = take && last_char;
  assign push_data.fmt_ok = !err_now && (char_position == TS_LAST_POS);
  assign push_data.year   = year_accum;
  assign push_data.month  = month_accum;
  assign push_data.day    = day_accum;
  assign push_data.hour   = hour_accum;
  assign push_data.minute = minute_accum;
  assign push_data.second = second_accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      year_accum    <= '0;
      month_accum   <= '0;
      day_accum     <= '0;
      hour_accum    <= '0;
      minute_accum  <= '0;
      second_accum  <= '0;
      format_error  <= 1'b0;
    end else if (take) begin
      char_position <= char_position_next;
      year_accum    <= year_accum_next;
      month_accum   <= month_accum_next;
      day_accum     <= day_accum_next;
      hour_accum    <= hour_accum_next;
      minute_accum  <= minute_accum_next;
      second_accum  <= second_accum_next;
      format_error  <= format_error_next;
    end
  end

`ifndef SYNTH
  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && last_char |=> char_position == '0 && !format_error)
    else $error("parser did not restart after final character");
`endif

endmodule

@@ sv/iutc_queue.sv @@
`timescale 1ns / 1ps
// Short queue of parsed records between the parser and the converter.
// Depends on iutc_pkg for ts_rec_t.
module iutc_queue import iutc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  ts_rec_t push_data,
  output logic    full,
  input  logic    pop,
  output ts_rec_t pop_data,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ts_rec_t        mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

@@ sv/iutc_convert.sv @@
`timescale 1ns / 1ps
// Back end: range checks a parsed record and converts it to epoch milliseconds.
// Depends on iutc_pkg; takes records from iutc_queue and drives the result register.
module iutc_convert import iutc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  ts_rec_t     pop_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [47:0] unix_ms
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_YEAR  = 6'b000010,
    ST_PARTS = 6'b000100,
    ST_DAYS  = 6'b001000,
    ST_SECS  = 6'b010000,
    ST_MS    = 6'b100000
  } conv_state_t;

  conv_state_t state, state_next;
  ts_rec_t     rec;
  logic        range_ok;
  logic [12:0] dy;
  logic [7:0]  q1, q2;
  logic [21:0] yd;
  logic [10:0] lp;
  logic [8:0]  doy;
  logic [16:0] tod;
  logic [21:0] days;
  logic [37:0] secs;

  logic [13:0] ym1;
  logic [26:0] prod1, prod2;
  logic [13:0] leaps_w;
  logic [13:0] rem100;
  logic        div100, leap_y, leap_add;
  logic [3:0]  mon_idx;
  logic [47:0] secs_w, ms_w;
  logic        load_out, ok_w;

  assign ym1   = rec.year - 14'd1;
  // Division by 100 through a reciprocal, exact for any 14-bit year.
  assign prod1 = {13'd0, ym1} * {14'd0, DIV100_MUL};
  assign prod2 = {13'd0, rec.year} * {14'd0, DIV100_MUL};

  assign leaps_w  = {2'd0, ym1[13:2]} - {6'd0, q1} + {8'd0, q1[7:2]} - LEAPS_1969;
  assign rem100   = rec.year - 14'({6'd0, q2} * 14'd100);
  assign div100   = (rem100 == '0);
  assign leap_y   = (rec.year[1:0] == 2'd0 && !div100) || (div100 && q2[1:0] == 2'd0);
  assign leap_add = (rec.month > FEBRUARY) && leap_y;
  assign mon_idx  = rec.month[3:0] - 4'd1;

  // Times 1000 as shifts: 1024 - 16 - 8.
  assign secs_w = {10'd0, secs};
  assign ms_w   = (secs_w << 10) - (secs_w << 4) - (secs_w << 3);
  assign ok_w   = rec.fmt_ok && range_ok && (secs != '0);

  assign pop      = (state == ST_IDLE) && !empty;
  assign load_out = (state == ST_MS) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!empty) state_next = ST_YEAR;
      ST_YEAR:  state_next = ST_PARTS;
      ST_PARTS: state_next = ST_DAYS;
      ST_DAYS:  state_next = ST_SECS;
      ST_SECS:  state_next = ST_MS;
      ST_MS:    if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= pop_data;
    end
    if (state == ST_YEAR) begin
      q1       <= 8'(prod1 >> DIV100_SHIFT);
      q2       <= 8'(prod2 >> DIV100_SHIFT);
      dy       <= 13'(rec.year - EPOCH_YEAR);
      range_ok <= (rec.year >= EPOCH_YEAR)
               && (rec.month >= 7'd1) && (rec.month <= MAX_MONTH)
               && (rec.day >= 7'd1) && (rec.day <= MAX_DAY)
               && (rec.hour <= MAX_HOUR)
               && (rec.minute <= MAX_MINUTE)
               && (rec.second <= MAX_SECOND);
    end
    if (state == ST_PARTS) begin
      yd  <= {9'd0, dy} * 22'd365;
      lp  <= leaps_w[10:0];
      doy <= days_before_month(mon_idx) + {8'd0, leap_add} + {2'd0, rec.day} - 9'd1;
      tod <= {10'd0, rec.hour} * 17'd3600 + {10'd0, rec.minute} * 17'd60
           + {10'd0, rec.second};
    end
    if (state == ST_DAYS) begin
      days <= yd + {11'd0, lp} + {13'd0, doy};
    end
    if (state == ST_SECS) begin
      secs <= {16'd0, days} * 38'd86400 + {21'd0, tod};
    end
    if (load_out) begin
      valid_res <= ok_w;
      unix_ms   <= ok_w ? ms_w : '0;
    end
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("converter state not one-hot");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> unix_ms == '0)
    else $error("invalid result carries a non-zero time");
`endif

endmodule

@@ sv/iso_utc_timestamp_to_epoch_ms_top.sv @@
`timescale 1ns / 1ps
// A result is registered once the final character has passed the queue and five steps
// of the converter sequencer; an output stall delays it further. One character is taken
// per cycle while the record queue has room; the converter handles one string at a time,
// so finished strings wait in the record queue. Synchronous active-high reset
// clears the parser position and fields, the queue and the converter state.
module iso_utc_timestamp_to_epoch_ms_top import iutc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [47:0] unix_ms
);

  // The parser takes a character whenever the record queue has room, so one
  // string may be parsed while the previous one is still being converted.
  logic    take, push, full, pop, empty;
  ts_rec_t push_data, pop_data;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  // Front end: position tracking, separator checks and digit collection.
  iutc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue: one entry per finished string.
  iutc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back end: range check, calendar arithmetic and the result register. The
  // result register frees the converter as soon as its contents are transferred.
  iutc_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .unix_ms   (unix_ms)
  );

endmodule
